// ----- design/pq_distance_topk_search_top_macros.svh -----
// Assertion macros shared by the checker of the search block.
`ifndef PQ_DISTANCE_TOPK_SEARCH_TOP_MACROS_SVH
`define PQ_DISTANCE_TOPK_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define PQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("search block check failed");

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define PQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("search block check failed");

`endif

// ----- design/pqs_pkg.sv -----
`default_nettype none
package pqs_pkg;

    localparam logic [1:0] CMD_LOAD_CODE  = 2'd0;
    localparam logic [1:0] CMD_LOAD_TABLE = 2'd1;
    localparam logic [1:0] CMD_SEARCH     = 2'd2;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam logic [1:0] CFG_CHUNKS     = 2'd0;
    localparam logic [1:0] CFG_CODEBOOK   = 2'd1;
    localparam logic [1:0] CFG_BASE       = 2'd2;
    localparam logic [1:0] CFG_RESULTS    = 2'd3;

    localparam int CODE_AW  = 16;
    localparam int ID_W     = 13;
    localparam int GROUP    = 4;
    localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        location;
        logic [7:0]         code_byte;
        logic signed [23:0] table_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         rank;
        logic [11:0]        vector_id;
        logic signed [31:0] distance;
        logic               found;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  chunks_in_use;
        logic [8:0]  codebook_size;
        logic [12:0] base_count;
        logic [6:0]  result_count;
    } cfg_t;

endpackage
`default_nettype wire

// ----- design/pqs_ram.sv -----
`default_nettype none
module pqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/pqs_front.sv -----
`default_nettype none
module pqs_front
    import pqs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          q_valid,
    output in_item_t      q_item,
    input  wire logic     q_pop
);

    // Two-entry queue; unknown commands are dropped on entry.
    in_item_t slot_reg [2];
    logic     wr_ptr_reg;
    logic     rd_ptr_reg;
    logic [1:0] count_reg;
    logic     push;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall && (in_data.cmd != CMD_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule
`default_nettype wire

// ----- design/pqs_back.sv -----
`default_nettype none
module pqs_back
    import pqs_pkg::*;
#(
    parameter int MAX_VECTORS    = 4096,
    parameter int MAX_CHUNKS     = 16,
    parameter int CODEBOOK_DEPTH = 256,
    parameter int MAX_K          = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     q_valid,
    input  wire in_item_t q_item,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    localparam int TD      = MAX_CHUNKS * CODEBOOK_DEPTH;
    localparam int TAW     = $clog2(TD);
    localparam bit TD_POW2 = ((TD & (TD - 1)) == 0);
    localparam int     REM_SH    = 16 + TAW;
    localparam longint REM_RECIP = ((longint'(1) << REM_SH) + longint'(TD) - 1) / longint'(TD);

    typedef enum logic [2:0] {S_IDLE, S_TREM, S_PREP, S_SCAN, S_FLUSH, S_EMIT} state_t;

    state_t state_reg;

    // Search settings latched at the start of a search.
    logic [5:0]      chunks_reg;
    logic [ID_W-1:0] n_reg;
    logic [6:0]      k_reg;
    logic [TAW-1:0]  cbs_mod_reg;

    // Remainder by the table depth: a reciprocal multiply gives the quotient, which is
    // registered; a multiply by the depth and a subtract then give the remainder.
    logic [15:0]     rem_src_reg;
    logic [15:0]     rem_q_reg;
    logic [4:0]      rem_cnt_reg;
    logic [33:0]     rem_prod;
    logic [15:0]     rem_q_next;
    logic [31:0]     rem_diff;
    logic [TAW-1:0]  rem_red;
    logic signed [23:0] ld_value_reg;

    // Scan issue counters.
    logic [ID_W-1:0] j_reg;
    logic [5:0]      m_reg;
    logic [15:0]     vbase_reg;
    logic            issue;
    logic            issue_last;

    // Pipeline stages.
    logic            a_valid_reg, a_rd_reg, a_first_reg, a_last_reg;
    logic [ID_W-1:0] a_id_reg;
    logic            b_valid_reg, b_rd_reg, b_first_reg, b_last_reg;
    logic [ID_W-1:0] b_id_reg;
    logic            c_valid_reg;
    logic signed [31:0] c_dist_reg;
    logic [ID_W-1:0] c_id_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic [TAW-1:0]  rb_next_reg;
    logic [TAW-1:0]  rowbase_cur;
    logic [TAW:0]    rb_sum;
    logic [TAW:0]    ta_sum;
    logic [TAW-1:0]  rb_red;
    logic [TAW-1:0]  ta_red;
    logic [TAW-1:0]  codemod [256];

    // Memories.
    logic               code_we;
    logic [7:0]         code_rdata;
    logic               tab_we;
    logic [TAW-1:0]     tab_waddr;
    logic signed [23:0] tab_wdata;
    logic [23:0]        tab_rdata;

    // Sorted list of kept candidates, ascending.
    logic signed [31:0] heap_d_reg  [MAX_K];
    logic [ID_W-1:0]    heap_id_reg [MAX_K];
    logic               heap_v_reg  [MAX_K];
    logic signed [31:0] heap_d_next  [MAX_K];
    logic [ID_W-1:0]    heap_id_next [MAX_K];
    logic               heap_v_next  [MAX_K];
    logic               gt [MAX_K];
    logic               heap_clear;
    logic               heap_shift;

    logic [6:0]  rank_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic        emit;
    logic        start;

    logic [5:0]      chunks_round;
    logic [5:0]      chunks_eff;
    logic [ID_W-1:0] n_eff;
    logic [6:0]      k_eff;

    genvar g;
    for (g = 0; g < 256; g++)
    begin : g_codemod
        assign codemod[g] = TAW'(g % TD);
    end

    assign q_pop = q_valid && (state_reg == S_IDLE);
    assign start = q_pop && (q_item.cmd == CMD_SEARCH) && (k_eff != 7'd0);

    always_comb
    begin
        chunks_round = (6'({1'b0, cfg.chunks_in_use}) + 6'(GROUP - 1)) & ~6'(GROUP - 1);
        chunks_eff   = (32'(chunks_round) > MAX_CHUNKS) ? 6'(MAX_CHUNKS) : chunks_round;
        n_eff        = (32'(cfg.base_count) > MAX_VECTORS) ? ID_W'(MAX_VECTORS)
                                                           : cfg.base_count;
        k_eff        = (32'(cfg.result_count) > MAX_K) ? 7'(MAX_K) : cfg.result_count;
    end

    always_comb
    begin
        rem_prod   = 34'(rem_src_reg) * 34'(REM_RECIP);
        rem_q_next = 16'(rem_prod >> REM_SH);
        rem_diff   = 32'(rem_src_reg) - 32'(rem_q_reg) * 32'(TD);
        rem_red    = TAW'(rem_diff);
    end

    // Row base and table address for the beat in stage A.
    always_comb
    begin
        rowbase_cur = a_first_reg ? '0 : rb_next_reg;
        rb_sum = {1'b0, rowbase_cur} + {1'b0, cbs_mod_reg};
        rb_red = (rb_sum >= (TAW+1)'(TD)) ? TAW'(rb_sum - (TAW+1)'(TD)) : TAW'(rb_sum);
        ta_sum = {1'b0, rowbase_cur} + {1'b0, codemod[code_rdata]};
        ta_red = (ta_sum >= (TAW+1)'(TD)) ? TAW'(ta_sum - (TAW+1)'(TD)) : TAW'(ta_sum);
    end

    assign issue      = (state_reg == S_SCAN);
    assign issue_last = (chunks_reg == 6'd0) || (m_reg == chunks_reg - 6'd1);

    assign code_we = q_pop && (q_item.cmd == CMD_LOAD_CODE);

    always_comb
    begin
        tab_we    = 1'b0;
        tab_waddr = rem_red;
        tab_wdata = ld_value_reg;
        if (TD_POW2)
        begin
            tab_we    = q_pop && (q_item.cmd == CMD_LOAD_TABLE);
            tab_waddr = q_item.location[TAW-1:0];
            tab_wdata = q_item.table_value;
        end
        else if ((state_reg == S_TREM) && (rem_cnt_reg == 5'd1))
        begin
            tab_we = 1'b1;
        end
    end

    pqs_ram #(.WIDTH(8), .DEPTH(2 ** CODE_AW)) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (q_item.location),
        .wdata (q_item.code_byte),
        .raddr (vbase_reg + {10'd0, m_reg}),
        .rdata (code_rdata)
    );

    pqs_ram #(.WIDTH(24), .DEPTH(TD)) u_table_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (ta_red),
        .rdata (tab_rdata)
    );

    assign acc_next = (b_first_reg ? 32'sd0 : acc_reg)
                    + (b_rd_reg ? 32'(signed'(tab_rdata)) : 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rd_reg    <= (chunks_reg != 6'd0);
        a_first_reg <= (m_reg == 6'd0);
        a_last_reg  <= issue_last;
        a_id_reg    <= j_reg;
        if (a_valid_reg)
        begin
            rb_next_reg <= rb_red;
        end
        b_rd_reg    <= a_rd_reg;
        b_first_reg <= a_first_reg;
        b_last_reg  <= a_last_reg;
        b_id_reg    <= a_id_reg;
        if (b_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        c_dist_reg  <= acc_next;
        c_id_reg    <= b_id_reg;
    end

    assign emit       = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign heap_clear = start;
    assign heap_shift = emit;

    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            gt[i] = heap_d_reg[i] > c_dist_reg;
        end
        for (int i = 0; i < MAX_K; i++)
        begin
            heap_d_next[i]  = heap_d_reg[i];
            heap_id_next[i] = heap_id_reg[i];
            heap_v_next[i]  = heap_v_reg[i];
            if (heap_clear)
            begin
                heap_d_next[i] = DIST_MAX;
                heap_v_next[i] = 1'b0;
            end
            else if (heap_shift)
            begin
                if (i == MAX_K - 1)
                begin
                    heap_d_next[i] = DIST_MAX;
                    heap_v_next[i] = 1'b0;
                end
                else
                begin
                    heap_d_next[i]  = heap_d_reg[i+1];
                    heap_id_next[i] = heap_id_reg[i+1];
                    heap_v_next[i]  = heap_v_reg[i+1];
                end
            end
            else if (c_valid_reg && gt[i])
            begin
                if (i == 0 || !gt[(i == 0) ? 0 : i-1])
                begin
                    heap_d_next[i]  = c_dist_reg;
                    heap_id_next[i] = c_id_reg;
                    heap_v_next[i]  = 1'b1;
                end
                else
                begin
                    heap_d_next[i]  = heap_d_reg[(i == 0) ? 0 : i-1];
                    heap_id_next[i] = heap_id_reg[(i == 0) ? 0 : i-1];
                    heap_v_next[i]  = heap_v_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            heap_d_reg[i]  <= heap_d_next[i];
            heap_id_reg[i] <= heap_id_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                heap_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                heap_v_reg[i] <= heap_v_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chunks_reg    <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            cbs_mod_reg   <= '0;
            rem_q_reg     <= '0;
            rem_src_reg   <= '0;
            rem_cnt_reg   <= '0;
            ld_value_reg  <= '0;
            j_reg         <= '0;
            m_reg         <= '0;
            vbase_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rem_cnt_reg != 5'd0)
            begin
                if (rem_cnt_reg == 5'd2)
                begin
                    rem_q_reg <= rem_q_next;
                end
                rem_cnt_reg <= rem_cnt_reg - 5'd1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && (q_item.cmd == CMD_LOAD_TABLE) && !TD_POW2)
                    begin
                        ld_value_reg <= q_item.table_value;
                        rem_src_reg  <= q_item.location;
                        rem_cnt_reg  <= 5'd2;
                        state_reg    <= S_TREM;
                    end
                    else if (start)
                    begin
                        chunks_reg  <= chunks_eff;
                        n_reg       <= n_eff;
                        k_reg       <= k_eff;
                        rem_src_reg <= {7'd0, cfg.codebook_size};
                        rem_cnt_reg <= 5'd2;
                        state_reg   <= S_PREP;
                    end
                end
                S_TREM:
                begin
                    if (rem_cnt_reg == 5'd1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PREP:
                begin
                    if (rem_cnt_reg == 5'd1)
                    begin
                        cbs_mod_reg <= rem_red;
                        j_reg       <= '0;
                        m_reg       <= '0;
                        vbase_reg   <= '0;
                        state_reg   <= (n_reg == '0) ? S_FLUSH : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (issue_last)
                    begin
                        m_reg     <= '0;
                        vbase_reg <= vbase_reg + {10'd0, chunks_reg};
                        j_reg     <= j_reg + 1'b1;
                        if (j_reg == n_reg - 1'b1)
                        begin
                            state_reg <= S_FLUSH;
                        end
                    end
                    else
                    begin
                        m_reg <= m_reg + 6'd1;
                    end
                end
                S_FLUSH:
                begin
                    if (!a_valid_reg && !b_valid_reg && !c_valid_reg)
                    begin
                        rank_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit)
                    begin
                        out_data_reg.rank      <= rank_reg[5:0];
                        out_data_reg.vector_id <= heap_v_reg[0] ? heap_id_reg[0][11:0] : 12'd0;
                        out_data_reg.distance  <= heap_d_reg[0];
                        out_data_reg.found     <= heap_v_reg[0];
                        out_data_reg.last      <= (rank_reg == k_reg - 7'd1);
                        rank_reg               <= rank_reg + 7'd1;
                        if (rank_reg == k_reg - 7'd1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- design/pq_distance_topk_search_top.sv -----
// Load beats (code bytes, table entries) are taken while the back end is idle; when the
// table depth is not a power of two a table entry first goes through the two-step remainder.
// A search holds the back end through set-up, a scan of one code byte per cycle (at zero
// chunks each vector is issued without a table read), a drain of the read pipeline and
// one result per cycle when the output does not stall. Reset is asynchronous and
// active low; memories are not cleared, configuration returns to 16, 256, 4096 and 10.
`default_nettype none
module pq_distance_topk_search_top
    import pqs_pkg::*;
#(
    parameter int MAX_VECTORS    = 4096,
    parameter int MAX_CHUNKS     = 16,
    parameter int CODEBOOK_DEPTH = 256,
    parameter int MAX_K          = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    // The front queue takes beats and drops unknown commands; the back engine
    // performs loads, scans the code store through a short read pipeline and
    // keeps the best candidates in a sorted row of registers.
    cfg_t     cfg_reg;
    logic     q_valid;
    in_item_t q_item;
    logic     q_pop;

    // The user must write configuration only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunks_in_use <= 5'd16;
            cfg_reg.codebook_size <= 9'd256;
            cfg_reg.base_count    <= 13'd4096;
            cfg_reg.result_count  <= 7'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHUNKS:   cfg_reg.chunks_in_use <= cfg_data[4:0];
                CFG_CODEBOOK: cfg_reg.codebook_size <= cfg_data[8:0];
                CFG_BASE:     cfg_reg.base_count    <= cfg_data;
                CFG_RESULTS:  cfg_reg.result_count  <= cfg_data[6:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    pqs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pqs_back #(
        .MAX_VECTORS    (MAX_VECTORS),
        .MAX_CHUNKS     (MAX_CHUNKS),
        .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
        .MAX_K          (MAX_K)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ----- design/pqs_checker.sv -----
`default_nettype none
`include "pq_distance_topk_search_top_macros.svh"
module pqs_checker
    import pqs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    logic               beat;
    logic               pend_reg;
    logic [5:0]         prev_rank_reg;
    logic signed [31:0] prev_dist_reg;
    logic               prev_found_reg;

    assign beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            prev_rank_reg  <= '0;
            prev_dist_reg  <= '0;
            prev_found_reg <= 1'b0;
        end
        else if (beat)
        begin
            pend_reg       <= !out_data.last;
            prev_rank_reg  <= out_data.rank;
            prev_dist_reg  <= out_data.distance;
            prev_found_reg <= out_data.found;
        end
    end

    `PQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `PQS_ASSERT_NOW(a_empty_slot, beat && !out_data.found, (out_data.distance == DIST_MAX) && (out_data.vector_id == 12'd0))
    `PQS_ASSERT_NOW(a_ascending, beat && pend_reg, (out_data.rank == prev_rank_reg + 6'd1) && (out_data.distance >= prev_dist_reg))
    `PQS_ASSERT_NOW(a_empty_tail, beat && pend_reg && !prev_found_reg, !out_data.found)

endmodule

bind pq_distance_topk_search_top pqs_checker u_pqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

// ----- bench/pq_distance_topk_search_top_tb.sv -----
`timescale 1ns / 1ps

module pq_distance_topk_search_top_tb;
    import pqs_pkg::*;

    // Predicts the ranked results of every search and checks each result
    // beat against the oldest prediction still outstanding.
    class topk_scoreboard;
        logic [7:0]  code_mem [65536];
        int          dist_rows [4096];
        int unsigned chunks_reg;
        int unsigned codebook_reg;
        int unsigned base_reg;
        int unsigned results_reg;
        out_item_t   ranked_q [$];
        int          errors;
        int          searches;
        int          checked;

        function new();
            chunks_reg   = 16;
            codebook_reg = 256;
            base_reg     = 4096;
            results_reg  = 10;
            errors       = 0;
            searches     = 0;
            checked      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                CFG_CHUNKS:   chunks_reg   = val[4:0];
                CFG_CODEBOOK: codebook_reg = val[8:0];
                CFG_BASE:     base_reg     = val[12:0];
                CFG_RESULTS:  results_reg  = val[6:0];
                default: ;
            endcase
        endfunction

        function void note_beat(in_item_t b);
            int unsigned    ch;
            int unsigned    n;
            int unsigned    k;
            int unsigned    p;
            int unsigned    ta;
            longint         s;
            int             kd [64];
            int unsigned    kid [64];
            bit             kv [64];
            out_item_t      r;
            case (b.cmd)
                CMD_LOAD_CODE:  code_mem[b.location] = b.code_byte;
                CMD_LOAD_TABLE: dist_rows[b.location % 4096] = int'(b.table_value);
                CMD_SEARCH:
                begin
                    searches++;
                    ch = (chunks_reg + GROUP - 1) / GROUP * GROUP;
                    if (ch > 16) ch = 16;
                    n = (base_reg > 4096) ? 4096 : base_reg;
                    k = (results_reg > 64) ? 64 : results_reg;
                    for (int i = 0; i < 64; i++)
                    begin
                        kd[i] = DIST_MAX;
                        kid[i] = 0;
                        kv[i] = 0;
                    end
                    if (k == 0) return;
                    for (int unsigned j = 0; j < n; j++)
                    begin
                        s = 0;
                        for (int unsigned m = 0; m < ch; m++)
                        begin
                            ta = (m * codebook_reg + code_mem[(j * ch + m) % 65536]) % 4096;
                            s += dist_rows[ta];
                        end
                        if (s > 64'sd2147483647) s = 64'sd2147483647;
                        if (s < -64'sd2147483648) s = -64'sd2147483648;
                        // Only a strictly smaller sum displaces the largest kept one.
                        if (s < kd[k-1])
                        begin
                            p = 0;
                            while (p < k && kd[p] <= s) p++;
                            for (int unsigned i = k - 1; i > p; i--)
                            begin
                                kd[i] = kd[i-1];
                                kid[i] = kid[i-1];
                                kv[i] = kv[i-1];
                            end
                            kd[p] = int'(s);
                            kid[p] = j;
                            kv[p] = 1;
                        end
                    end
                    for (int unsigned i = 0; i < k; i++)
                    begin
                        r.rank      = i[5:0];
                        r.vector_id = kv[i] ? kid[i][11:0] : 12'd0;
                        r.distance  = kd[i];
                        r.found     = kv[i];
                        r.last      = (i == k - 1);
                        ranked_q.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_beat(out_item_t got);
            out_item_t want;
            if (ranked_q.size() == 0)
            begin
                report($sformatf("unexpected result beat %p", got));
                return;
            end
            want = ranked_q.pop_front();
            checked++;
            if (got.rank !== want.rank)
                report($sformatf("rank %0d, wanted %0d", got.rank, want.rank));
            if (got.vector_id !== want.vector_id)
                report($sformatf("rank %0d id %0d, wanted %0d",
                                 want.rank, got.vector_id, want.vector_id));
            if (got.distance !== want.distance)
                report($sformatf("rank %0d distance %0d, wanted %0d",
                                 want.rank, got.distance, want.distance));
            if (got.found !== want.found)
                report($sformatf("rank %0d found %b, wanted %b",
                                 want.rank, got.found, want.found));
            if (got.last !== want.last)
                report($sformatf("rank %0d last %b, wanted %b",
                                 want.rank, got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    topk_scoreboard ranking;

    // Receiver side: a long hold-off asked for by the stimulus, otherwise a
    // stall pattern whose density changes every so often.
    bit          long_hold_req;
    int          hold_left;
    int          mode_left;
    int          stall_mode;
    int          idle_cycles;

    pq_distance_topk_search_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Every accepted result beat is checked in arrival order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ranking.check_beat(out_data);
    end

    always @(posedge clk)
    begin
        if (long_hold_req && hold_left == 0)
        begin
            long_hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // The watchdog only counts cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 100000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Holds the beat until the block accepts it. Valid is left high so that
    // the next beat of a burst follows without a gap.
    task send_beat(in_item_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        ranking.note_beat(b);
    endtask

    task pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits for every predicted result, then a little longer so that a
    // trailing load has left the pipeline too.
    task drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (ranking.ranked_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ranking.set_reg(idx, val);
    endtask

    task set_search(logic [12:0] ch, logic [12:0] cb, logic [12:0] nb, logic [12:0] kr);
        write_reg(CFG_CHUNKS, ch);
        write_reg(CFG_CODEBOOK, cb);
        write_reg(CFG_BASE, nb);
        write_reg(CFG_RESULTS, kr);
    endtask

    // Random beats are mostly loads into the region that searches read, so
    // that they change the ranking; searches come often enough to see it.
    // Code bytes stay below four, so every table entry that a search can
    // reach lies in the first 64 entries.
    function automatic in_item_t random_beat();
        in_item_t b;
        int       pick;
        b = in_item_t'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            b.cmd = CMD_LOAD_CODE;
            b.code_byte = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
                b.location = 16'($urandom_range(0, 127));
        end
        else if (pick < 70)
        begin
            b.cmd = CMD_LOAD_TABLE;
            if ($urandom_range(0, 4) != 0)
                b.location = 16'($urandom_range(0, 63));
            // Small values make equal sums, and so ties, common.
            if ($urandom_range(0, 1) == 0)
                b.table_value = 24'($signed($urandom_range(0, 16)) - 8);
        end
        else if (pick < 75)
            b.cmd = CMD_NONE;
        else
            b.cmd = CMD_SEARCH;
        return b;
    endfunction

    task random_items(int count, bit pause_midway);
        int       sent;
        int       burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_beat(random_beat());
                sent++;
            end
            if (pause_midway && sent >= count / 2)
            begin
                pause_midway = 0;
                drain();
            end
            else if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        in_item_t b;
        logic [12:0] phase_cfg [8][4];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        long_hold_req = 0;
        hold_left = 0;
        mode_left = 0;
        stall_mode = 0;
        idle_cycles = 0;
        ranking = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The stores come up undefined, so every table entry and every code
        // byte that any search can reach is written before the first search.
        // Searches keep to the first 128 code bytes and the first 64 entries.
        for (int a = 0; a < 64; a++)
        begin
            b = in_item_t'({$urandom, $urandom});
            b.cmd = CMD_LOAD_TABLE;
            b.location = 16'(a);
            b.table_value = 24'($signed($urandom_range(0, 2000)) - 1000);
            send_beat(b);
        end
        for (int a = 0; a < 128; a++)
        begin
            b = in_item_t'({$urandom, $urandom});
            b.cmd = CMD_LOAD_CODE;
            b.location = 16'(a);
            b.code_byte = 8'($urandom_range(0, 3));
            send_beat(b);
        end
        drain();

        // Directed part: field extremes, the unused command, and the widest
        // scan, which reads no code bytes at zero chunks (base saturated).
        b = '0;
        b.cmd = CMD_LOAD_CODE;  b.location = 16'hFFFF; b.code_byte = 8'hFF;
        send_beat(b);
        b.location = 16'h0000; b.code_byte = 8'h00;
        send_beat(b);
        b.cmd = CMD_LOAD_TABLE; b.location = 16'hFFFF; b.table_value = 24'sh7FFFFF;
        send_beat(b);
        b.location = 16'h0000; b.table_value = -24'sh800000;
        send_beat(b);
        b.location = 16'h0040; b.table_value = 24'sh7FFFFF;
        send_beat(b);
        b.cmd = CMD_NONE; b.location = 16'hFFFF; b.code_byte = 8'hFF;
        send_beat(b);
        drain();
        set_search(13'd0, 13'd256, 13'h1FFF, 13'd64);
        b.cmd = CMD_SEARCH;
        send_beat(b);
        drain();
        set_search(13'd16, 13'd4, 13'd8, 13'd10);
        send_beat(b);
        send_beat(b);
        drain();

        // Settings cover zero and odd chunk counts, a codebook of one and of
        // zero, empty scans, fewer vectors than results and oversized counts.
        phase_cfg = '{'{13'd16, 13'd4,   13'd8,  13'd10},
                      '{13'd0,  13'd7,   13'd20, 13'd5},
                      '{13'd5,  13'd1,   13'd16, 13'd127},
                      '{13'd31, 13'd0,   13'd3,  13'd64},
                      '{13'd12, 13'd5,   13'd10, 13'd1},
                      '{13'd4,  13'd9,   13'd16, 13'd0},
                      '{13'd16, 13'd3,   13'd0,  13'd3},
                      '{13'd8,  13'd8,   13'd16, 13'd20}};
        for (int p = 0; p < 8; p++)
        begin
            set_search(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            if (p == 0)
                long_hold_req = 1;
            random_items(26, p == 2);
            drain();
        end

        $display("Covered %0d searches with %0d result beats checked over eight settings,",
                 ranking.searches, ranking.checked);
        $display("including a saturated scan, empty slots, ties and long output stalls.");
        if (ranking.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
